FILE: rtl/kce_pkg.sv
// Package for the knapsack cipher engine: payload structs, operation and
// register codes, and default sizes. Used by the top level and kce_chk in rtl.
package kce_pkg;

    localparam int KCE_ELEMENTS   = 32;
    localparam int KCE_VALUE_BITS = 40;

    typedef enum logic [1:0] {
        OP_LOAD_PUB  = 2'd0,
        OP_LOAD_PRIV = 2'd1,
        OP_ENCRYPT   = 2'd2,
        OP_DECRYPT   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_MODULUS = 2'd0,
        CFG_INVERSE = 2'd1,
        CFG_COUNT   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  entry_index;
        logic [39:0] key_value;
        logic [31:0] plain_bits;
        logic [47:0] cipher_value;
    } t_in;

    typedef struct packed {
        logic [47:0] cipher_out;
        logic [31:0] plain_out;
        logic        residual_left;
    } t_out;

endpackage

FILE: rtl/knapsack_cipher_engine.sv
// Top level of the knapsack cipher engine: sequencer, shared subtractor and
// the two key tables. Depends on kce_pkg and kce_ram.
//
// Usage: present an item on i_in and raise start while busy is low; the item
// is transferred at that clock edge. Exactly one result follows, shown on o_out
// for one cycle with o_strobe high; the receiver cannot stall it.
// Loads write the key table at the transfer edge and report a zero result in
// the next cycle, so a load can be issued every cycle.
// Encrypt reads the public table one entry at a time for the n elements in use.
// Decrypt runs on one shared compare-subtract unit: it reduces the ciphertext,
// then the inverse, bit by bit, runs the shift-and-add modular multiply, then the
// greedy scan reads and compares each private entry visited, with a subtract step
// when a pass ends by subtracting the entry before the one above the remainder
// (at most n passes of up to n entries). busy stays high while an item is in
// work; o_strobe shows in the cycle busy falls, if it rose. Configuration must be
// written through i_cfg_we only while the block is idle; no logic enforces it.
// Reset clears the sequencer and loads the register reset values; the key
// tables keep whatever they hold and must be loaded before use.
module knapsack_cipher_engine #(
    parameter int ELEMENTS   = kce_pkg::KCE_ELEMENTS,
    parameter int VALUE_BITS = kce_pkg::KCE_VALUE_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  kce_pkg::t_in  i_in,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [39:0]   i_cfg_data,
    output logic          o_strobe,
    output kce_pkg::t_out o_out
);
    import kce_pkg::*;

    localparam int IW  = $clog2(ELEMENTS);
    localparam int SUW = ((VALUE_BITS > 41) ? VALUE_BITS : 41) + 1;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_ENC_RD  = 10'b0000000010,
        S_ENC_ACC = 10'b0000000100,
        S_RED_C   = 10'b0000001000,
        S_RED_I   = 10'b0000010000,
        S_MUL_DBL = 10'b0000100000,
        S_MUL_ADD = 10'b0001000000,
        S_GR_RD   = 10'b0010000000,
        S_GR_CMP  = 10'b0100000000,
        S_GR_SUB  = 10'b1000000000
    } t_state;

    t_state                r_state, n_state;
    logic [39:0]           r_mod, r_inv;
    logic [5:0]            r_ecount;
    logic [5:0]            r_cnt, n_cnt;
    logic [39:0]           r_rem, n_rem;
    logic [39:0]           r_a, n_a;
    logic [39:0]           r_b, n_b;
    logic [47:0]           r_cval, n_cval;
    logic [31:0]           r_pbits, n_pbits;
    logic [IW-1:0]         r_idx, n_idx;
    logic [5:0]            r_pass, n_pass;
    logic [VALUE_BITS-1:0] r_prev, n_prev;
    logic [47:0]           r_acc, n_acc;
    logic [31:0]           r_plain, n_plain;
    logic                  r_strobe, n_strobe;
    t_out                  r_out, n_out;

    logic                  accept;
    logic [5:0]            n_used;
    logic [IW-1:0]         last_idx;
    logic [4:0]            bit_pos;
    logic [VALUE_BITS-1:0] pub_rdata, priv_rdata;
    logic                  we_pub, we_priv, idx_ok;

    // Shared compare-subtract unit.
    logic [SUW-1:0]        su_a, su_b;
    logic [SUW:0]          su_d;
    logic                  su_ge;

    // End of a greedy pass.
    logic                  pass_end;
    logic [39:0]           end_step;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    always_comb begin
        logic [5:0] lim;
        lim = (r_ecount > 6'(ELEMENTS)) ? 6'(ELEMENTS) : r_ecount;
        lim = lim & 6'b111000;
        n_used = (lim == 6'd0) ? 6'd8 : lim;
    end

    assign last_idx = IW'(n_used - 6'd1);
    assign bit_pos  = 5'd31 - 5'(r_idx);

    assign idx_ok  = ({1'b0, i_in.entry_index} < 6'(ELEMENTS));
    assign we_pub  = accept && (i_in.operation == OP_LOAD_PUB) && idx_ok;
    assign we_priv = accept && (i_in.operation == OP_LOAD_PRIV) && idx_ok;

    kce_ram #(.WIDTH(VALUE_BITS), .DEPTH(ELEMENTS)) u_pub_ram (
        .i_clk   (i_clk),
        .i_we    (we_pub),
        .i_waddr (i_in.entry_index[IW-1:0]),
        .i_wdata (VALUE_BITS'(i_in.key_value)),
        .i_raddr (r_idx),
        .o_rdata (pub_rdata)
    );

    kce_ram #(.WIDTH(VALUE_BITS), .DEPTH(ELEMENTS)) u_priv_ram (
        .i_clk   (i_clk),
        .i_we    (we_priv),
        .i_waddr (i_in.entry_index[IW-1:0]),
        .i_wdata (VALUE_BITS'(i_in.key_value)),
        .i_raddr (r_idx),
        .o_rdata (priv_rdata)
    );

    always_comb begin
        unique case (r_state)
            S_RED_C:   su_a = SUW'({r_rem, r_cval[r_cnt]});
            S_RED_I:   su_a = SUW'({r_rem, r_inv[r_cnt]});
            S_MUL_DBL: su_a = SUW'({r_rem, 1'b0});
            S_MUL_ADD: su_a = SUW'({1'b0, r_rem} + {1'b0, r_a});
            default:   su_a = SUW'(r_rem);
        endcase
        unique case (r_state)
            S_GR_CMP: su_b = SUW'(priv_rdata);
            S_GR_SUB: su_b = SUW'(r_prev);
            default:  su_b = SUW'(r_mod);
        endcase
        su_d  = {1'b0, su_a} - {1'b0, su_b};
        su_ge = !su_d[SUW];
    end

    always_comb begin
        logic [39:0] red;
        red = su_ge ? su_d[39:0] : su_a[39:0];

        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_a      = r_a;
        n_b      = r_b;
        n_cval   = r_cval;
        n_pbits  = r_pbits;
        n_idx    = r_idx;
        n_pass   = r_pass;
        n_prev   = r_prev;
        n_acc    = r_acc;
        n_plain  = r_plain;
        n_strobe = 1'b0;
        n_out    = r_out;
        pass_end = 1'b0;
        end_step = r_rem;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_in.operation))
                        OP_LOAD_PUB, OP_LOAD_PRIV: begin
                            n_strobe = 1'b1;
                            n_out    = '0;
                        end
                        OP_ENCRYPT: begin
                            n_idx   = '0;
                            n_acc   = '0;
                            n_pbits = i_in.plain_bits;
                            n_state = S_ENC_RD;
                        end
                        OP_DECRYPT: begin
                            if (r_mod == 40'd0) begin
                                n_strobe = 1'b1;
                                n_out    = '0;
                            end else begin
                                n_cval  = i_in.cipher_value;
                                n_rem   = '0;
                                n_cnt   = 6'd47;
                                n_state = S_RED_C;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ENC_RD: n_state = S_ENC_ACC;
            S_ENC_ACC: begin
                logic [47:0] sum;
                sum = r_pbits[bit_pos] ? (r_acc + 48'(pub_rdata)) : r_acc;
                n_acc = sum;
                if (r_idx == last_idx) begin
                    n_strobe = 1'b1;
                    n_out    = '{cipher_out: sum, plain_out: 32'd0, residual_left: 1'b0};
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ENC_RD;
                end
            end
            S_RED_C: begin
                n_rem = red;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_a     = red;
                    n_rem   = '0;
                    n_cnt   = 6'd39;
                    n_state = S_RED_I;
                end
            end
            S_RED_I: begin
                n_rem = red;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_b     = red;
                    n_rem   = '0;
                    n_cnt   = 6'd39;
                    n_state = S_MUL_DBL;
                end
            end
            S_MUL_DBL, S_MUL_ADD: begin
                n_rem = red;
                if ((r_state == S_MUL_DBL) && r_b[r_cnt]) begin
                    n_state = S_MUL_ADD;
                end else if (r_cnt == 6'd0) begin
                    // Product is ready; it becomes the remainder to decode.
                    n_plain = '0;
                    n_pass  = '0;
                    n_idx   = '0;
                    if (red == 40'd0) begin
                        n_strobe = 1'b1;
                        n_out    = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_GR_RD;
                    end
                end else begin
                    n_cnt   = r_cnt - 6'd1;
                    n_state = S_MUL_DBL;
                end
            end
            S_GR_RD: n_state = S_GR_CMP;
            S_GR_CMP: begin
                if (!su_ge) begin
                    // Entry is above the remainder.
                    if (r_idx == '0) begin
                        n_strobe = 1'b1;
                        n_out    = '{cipher_out: 48'd0, plain_out: r_plain,
                                     residual_left: 1'b1};
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_GR_SUB;
                    end
                end else if (r_idx == last_idx) begin
                    n_plain[bit_pos] = 1'b1;
                    pass_end = 1'b1;
                    end_step = su_d[39:0];
                end else begin
                    n_prev = priv_rdata;
                    n_idx  = r_idx + 1'b1;
                    n_state = S_GR_RD;
                end
            end
            S_GR_SUB: begin
                n_plain[5'd31 - 5'(r_idx - 1'b1)] = 1'b1;
                pass_end = 1'b1;
                end_step = su_d[39:0];
            end
            default: n_state = S_IDLE;
        endcase

        if (pass_end) begin
            n_rem  = end_step;
            n_pass = r_pass + 6'd1;
            n_idx  = '0;
            if ((r_pass + 6'd1 == n_used) || (end_step == 40'd0)) begin
                n_strobe = 1'b1;
                n_out    = '{cipher_out: 48'd0, plain_out: n_plain,
                             residual_left: (end_step != 40'd0)};
                n_state  = S_IDLE;
            end else begin
                n_state = S_GR_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_mod    <= 40'd1;
            r_inv    <= 40'd0;
            r_ecount <= 6'd32;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODULUS: r_mod    <= i_cfg_data;
                    CFG_INVERSE: r_inv    <= i_cfg_data;
                    CFG_COUNT:   r_ecount <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_a     <= n_a;
        r_b     <= n_b;
        r_cval  <= n_cval;
        r_pbits <= n_pbits;
        r_idx   <= n_idx;
        r_pass  <= n_pass;
        r_prev  <= n_prev;
        r_acc   <= n_acc;
        r_plain <= n_plain;
        r_out   <= n_out;
    end
endmodule

FILE: rtl/kce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kce_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/kce_chk.sv
// Port-level checker for the knapsack cipher engine, bound to the top level.
// Depends on kce_pkg.
module kce_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input kce_pkg::t_in  i_in,
    input logic          o_strobe,
    input kce_pkg::t_out o_out
);
    import kce_pkg::*;

    // A result is shown only while the block is idle, never while busy.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_in.operation == OP_LOAD_PUB ||
                            i_in.operation == OP_LOAD_PRIV))
        |=> (o_strobe && o_out == '0))
        else $error("load did not give a zero result");

    a_enc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.operation == OP_ENCRYPT) |=> (busy && !o_strobe))
        else $error("encrypt did not occupy the block");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_out.cipher_out == 48'd0 ||
                      (o_out.plain_out == 32'd0 && !o_out.residual_left)))
        else $error("result mixes encrypt and decrypt fields");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_strobe))
        else $error("reset did not clear the sequencer");
endmodule

bind knapsack_cipher_engine kce_chk u_kce_chk (.*);

FILE: sim/knapsack_cipher_engine_tb.sv
// Self-checking testbench for knapsack_cipher_engine: loads key tables, then runs
// encrypt, decrypt and key-reload traffic under several register settings and checks
// each result against a behavioral predictor. Depends on kce_pkg and the RTL in rtl.
module knapsack_cipher_engine_tb;
    import kce_pkg::*;

    localparam int NUM_KEYS      = 32;
    localparam int STALL_LIMIT   = 12000;
    localparam int ITEMS_PER_SET = 60;
    localparam int IN_BITS       = $bits(t_in);

    class kce_scoreboard;
        bit [39:0] pub_keys[NUM_KEYS];
        bit [39:0] priv_keys[NUM_KEYS];
        bit [39:0] modulus_reg;
        bit [39:0] inverse_reg;
        bit [5:0]  count_reg;
        t_out      pending[$];
        int        errors;

        function new();
            modulus_reg = 40'd1;
            inverse_reg = '0;
            count_reg   = 6'd32;
            errors      = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, bit [39:0] data);
            case (idx)
                CFG_MODULUS: modulus_reg = data;
                CFG_INVERSE: inverse_reg = data;
                CFG_COUNT:   count_reg   = data[5:0];
                default: ;
            endcase
        endfunction

        function int active_count();
            int n;
            n = (count_reg > NUM_KEYS) ? NUM_KEYS : count_reg;
            n = n & ~7;
            if (n == 0) n = 8;
            return n;
        endfunction

        // Shift-and-add product modulo m, operands already reduced.
        function bit [63:0] mulmod(bit [63:0] a, bit [63:0] b, bit [63:0] m);
            bit [63:0] r;
            r = 0;
            for (int k = 39; k >= 0; k--) begin
                r = (r << 1) % m;
                if (b[k]) r = (r + a) % m;
            end
            return r;
        endfunction

        function void note_input(t_in item);
            t_out      res;
            int        n;
            bit [63:0] sum, rem;
            bit        done;
            n   = active_count();
            res = '0;
            case (t_op'(item.operation))
                OP_LOAD_PUB:  pub_keys[item.entry_index]  = item.key_value;
                OP_LOAD_PRIV: priv_keys[item.entry_index] = item.key_value;
                OP_ENCRYPT: begin
                    sum = 0;
                    for (int j = 0; j < n; j++)
                        if (item.plain_bits[31 - j]) sum += 64'(pub_keys[j]);
                    res.cipher_out = sum[47:0];
                end
                default: begin
                    rem = 0;
                    if (modulus_reg != 0)
                        rem = mulmod(item.cipher_value % modulus_reg,
                                     inverse_reg % modulus_reg, modulus_reg);
                    for (int p = 0; p < n && rem != 0; p++) begin
                        done = 0;
                        for (int j = 0; j < n && !done; j++) begin
                            if (priv_keys[j] > rem) begin
                                if (j == 0) begin
                                    res.residual_left = 1'b1;
                                    rem = 0;
                                end else begin
                                    res.plain_out[32 - j] = 1'b1;
                                    rem -= 64'(priv_keys[j - 1]);
                                end
                                done = 1;
                            end else if (j == n - 1) begin
                                res.plain_out[31 - j] = 1'b1;
                                rem -= 64'(priv_keys[j]);
                                done = 1;
                            end
                        end
                    end
                    if (rem != 0) res.residual_left = 1'b1;
                end
            endcase
            pending = {pending, res};
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.cipher_out !== want.cipher_out) begin
                $display("%0t: cipher_out expected %h actual %h", $time,
                         want.cipher_out, got.cipher_out);
                errors++;
            end
            if (got.plain_out !== want.plain_out) begin
                $display("%0t: plain_out expected %h actual %h", $time,
                         want.plain_out, got.plain_out);
                errors++;
            end
            if (got.residual_left !== want.residual_left) begin
                $display("%0t: residual_left expected %b actual %b", $time,
                         want.residual_left, got.residual_left);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_in;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [39:0] i_cfg_data;
    logic        o_strobe;
    t_out        o_out;

    kce_scoreboard sb;
    int          stall_cycles;
    bit          no_gaps;
    bit          superinc;
    bit [39:0]   priv_mirror[NUM_KEYS];
    bit [39:0]   priv_total;

    knapsack_cipher_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_out      (o_out)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Transfers are noted before results are checked; a result never shares
    // the edge of its own transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_input(i_in);
            if (o_strobe) sb.check_result(o_out);
            if ((start && !busy) || o_strobe)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(t_in item);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(99) < 17) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in  <= item;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [39:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_load(t_op op, int idx, bit [39:0] value);
        t_in item;
        item = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
        item.operation   = op;
        item.entry_index = idx[4:0];
        item.key_value   = value;
        if (op == OP_LOAD_PRIV) priv_mirror[idx] = value;
        send_item(item);
    endtask

    task automatic send_crypt(t_op op, bit [31:0] bits, bit [47:0] cval);
        t_in item;
        item = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
        item.operation    = op;
        item.plain_bits   = bits;
        item.cipher_value = cval;
        send_item(item);
    endtask

    // Fills both tables; a superincreasing private table lets decrypts of its subset sums decode fully.
    task automatic load_keys(bit structured);
        bit [39:0] acc;
        acc = 0;
        superinc = structured;
        for (int j = 0; j < NUM_KEYS; j++) begin
            if (structured) begin
                priv_mirror[j] = acc + 40'($urandom_range(1, 15));
                acc += priv_mirror[j];
            end else begin
                priv_mirror[j] = 40'({$urandom, $urandom});
            end
            send_load(OP_LOAD_PRIV, j, priv_mirror[j]);
            send_load(OP_LOAD_PUB, j, 40'({$urandom, $urandom}));
        end
        priv_total = acc;
    endtask

    function automatic bit [47:0] subset_sum(bit [31:0] bits);
        bit [47:0] s;
        s = 0;
        for (int j = 0; j < NUM_KEYS; j++)
            if (bits[31 - j]) s += 48'(priv_mirror[j]);
        return s;
    endfunction

    task automatic random_traffic(int count);
        bit [31:0] bits;
        bit [47:0] cval;
        int        pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            bits = $urandom;
            if (pick < 8) begin
                // Reload one entry; a private reload drops the table's structure.
                if ($urandom_range(1)) begin
                    send_load(OP_LOAD_PUB, $urandom_range(31), 40'({$urandom, $urandom}));
                end else begin
                    send_load(OP_LOAD_PRIV, $urandom_range(31), 40'({$urandom, $urandom}));
                    superinc = 0;
                end
            end else if (pick < 45) begin
                send_crypt(OP_ENCRYPT, bits, 48'({$urandom, $urandom}));
            end else begin
                cval = 48'({$urandom, $urandom});
                if (superinc && $urandom_range(99) < 70)
                    cval = subset_sum(bits) + (($urandom_range(3) == 0) ? 48'd1 : 48'd0);
                send_crypt(OP_DECRYPT, {$urandom}, cval);
            end
        end
    endtask

    task automatic run_set(bit structured, int mode, bit [5:0] count);
        bit [39:0] modulus, inverse;
        wait_idle();
        load_keys(structured);
        wait_idle();
        case (mode)
            0: begin
                modulus = priv_total + 40'($urandom_range(1, 1000));
                inverse = 40'd1;
            end
            1: begin
                modulus = 40'({$urandom, $urandom});
                inverse = 40'({$urandom, $urandom});
            end
            2: begin modulus = '1; inverse = '1; end
            3: begin modulus = 40'd0; inverse = 40'({$urandom, $urandom}); end
            4: begin modulus = 40'd1; inverse = 40'({$urandom, $urandom}); end
            default: begin
                modulus = priv_total + 40'd1;
                inverse = 40'({$urandom, $urandom});
            end
        endcase
        write_reg(CFG_MODULUS, modulus);
        write_reg(CFG_INVERSE, inverse);
        write_reg(CFG_COUNT, {34'd0, count});
        random_traffic(ITEMS_PER_SET);
    endtask

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_in         = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_MODULUS;
        i_cfg_data   = '0;
        stall_cycles = 0;
        no_gaps      = 0;
        superinc     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme plaintexts and the reset register values, then exact
        // decodes, a remainder below the first entry, a remainder left over, and reloaded private entries.
        load_keys(1);
        send_crypt(OP_ENCRYPT, 32'h0, '0);
        send_crypt(OP_ENCRYPT, 32'hFFFF_FFFF, '1);
        send_crypt(OP_ENCRYPT, 32'h8000_0001, '0);
        send_crypt(OP_DECRYPT, '0, 48'hFFFF_FFFF_FFFF);
        wait_idle();
        write_reg(CFG_MODULUS, priv_total + 40'd5);
        write_reg(CFG_INVERSE, 40'd1);
        send_crypt(OP_DECRYPT, '0, subset_sum(32'hFFFF_FFFF));
        send_crypt(OP_DECRYPT, '0, subset_sum(32'h8000_0001));
        send_crypt(OP_DECRYPT, '0, 48'd0);
        send_crypt(OP_DECRYPT, '0, {8'd0, priv_mirror[0]} - 48'd1);
        send_crypt(OP_DECRYPT, '0, subset_sum(32'h0000_0001) + 48'd1);
        send_crypt(OP_DECRYPT, '0, 48'hFFFF_FFFF_FFFF);
        send_load(OP_LOAD_PRIV, 0, 40'hFF_FFFF_FFFF);
        send_crypt(OP_DECRYPT, '0, 48'd7);
        send_load(OP_LOAD_PRIV, 0, priv_mirror[1] - 40'd1);
        send_load(OP_LOAD_PRIV, 31, 40'd0);
        send_crypt(OP_DECRYPT, '0, 48'h1234_5678);

        run_set(1, 0, 6'd32);
        run_set(1, 0, 6'd8);
        run_set(1, 0, 6'd13);
        run_set(0, 1, 6'd63);
        run_set(0, 2, 6'd24);
        run_set(0, 3, 6'd0);
        run_set(0, 4, 6'd16);
        no_gaps = 1;
        run_set(1, 5, 6'd32);
        no_gaps = 0;
        run_set(1, 0, 6'd32);

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/kce_pkg.sv
rtl/kce_ram.sv
rtl/knapsack_cipher_engine.sv
rtl/kce_chk.sv
sim/knapsack_cipher_engine_tb.sv
